>>> sv/affinity_task_core_assigner_assert.svh
// Assertion macros for the affinity task core assigner
`ifndef AFFINITY_TASK_CORE_ASSIGNER_ASSERT_SVH
`define AFFINITY_TASK_CORE_ASSIGNER_ASSERT_SVH

`ifndef ASSERT_OFF
`define ATCA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ATCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ATCA_ASSERT(lbl, clk, rst_n, prop)
`define ATCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/atca_pkg.sv
// Shared types and constants for the affinity task core assigner
`default_nettype none
package atca_pkg;

  localparam int unsigned BatchSizeDef = 8;
  localparam int unsigned PosW         = 6;
  localparam int unsigned CntW         = PosW + 1;
  localparam int unsigned TypeW        = 8;
  localparam int unsigned LoadW        = 8;
  localparam int unsigned TotalW       = 32;
  localparam int unsigned CoreW        = 2;
  localparam int unsigned CostW        = 2;
  localparam int unsigned NumCores     = 3;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 8;
  localparam int unsigned OutDataW     = 48;

  localparam logic [TypeW-1:0] AffReset0 = 8'd72;
  localparam logic [TypeW-1:0] AffReset1 = 8'd77;
  localparam logic [TypeW-1:0] AffReset2 = 8'd76;

  localparam logic [CoreW-1:0] Core0 = 2'd0;
  localparam logic [CoreW-1:0] Core1 = 2'd1;
  localparam logic [CoreW-1:0] Core2 = 2'd2;

  localparam logic [CostW-1:0] CostNone = 2'd0;
  localparam logic [CostW-1:0] CostFast = 2'd1;
  localparam logic [CostW-1:0] CostSlow = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    RegMode = 2'd0,
    RegAff0 = 2'd1,
    RegAff1 = 2'd2,
    RegAff2 = 2'd3
  } cfg_reg_e;

  typedef logic [LoadW-1:0] load_t;
  typedef logic [TypeW-1:0] type_t;

  typedef struct packed {
    logic             assigned;
    logic [CoreW-1:0] core;
    logic [CostW-1:0] cost;
  } pick_t;

  typedef struct packed {
    logic              last;
    logic [LoadW-1:0]  span;
    logic [TotalW-1:0] total;
  } batch_t;

endpackage
`default_nettype wire

>>> sv/atca_pick.sv
// Core choice for one task: greedy affinity or round robin
`default_nettype none
module atca_pick (
  input  logic                                      mode_i,
  input  logic [atca_pkg::CoreW-1:0]                rr_core_i,
  input  atca_pkg::type_t                           task_type_i,
  input  atca_pkg::type_t [atca_pkg::NumCores-1:0]  aff_i,
  input  atca_pkg::load_t [atca_pkg::NumCores-1:0]  load_i,
  output atca_pkg::pick_t                           pick_o
);
  import atca_pkg::*;

  function automatic load_t load_at(input logic [CoreW-1:0] idx,
                                    input load_t [NumCores-1:0] loads);
    load_t res;
    case (idx)
      Core0:   res = loads[0];
      Core1:   res = loads[1];
      Core2:   res = loads[2];
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic type_t aff_at(input logic [CoreW-1:0] idx,
                                   input type_t [NumCores-1:0] affs);
    type_t res;
    case (idx)
      Core0:   res = affs[0];
      Core1:   res = affs[1];
      Core2:   res = affs[2];
      default: res = '0;
    endcase
    return res;
  endfunction

  logic [NumCores-1:0] match;
  logic                hit;
  logic [CoreW-1:0]    core_j, core_a, core_b, chosen;
  logic [LoadW:0]      lj, la, lb;

  always_comb begin
    for (int k = 0; k < NumCores; k++) begin
      match[k] = (aff_i[k] == task_type_i);
    end
    hit = |match;
    if (match[0]) begin
      core_j = Core0;
    end else if (match[1]) begin
      core_j = Core1;
    end else begin
      core_j = Core2;
    end
    core_a = (core_j == Core2) ? Core0 : core_j + 2'd1;
    core_b = (core_a == Core2) ? Core0 : core_a + 2'd1;

    lj = {1'b0, load_at(core_j, load_i)} + (LoadW+1)'(1);
    la = {1'b0, load_at(core_a, load_i)} + (LoadW+1)'(2);
    lb = {1'b0, load_at(core_b, load_i)} + (LoadW+1)'(2);

    if (mode_i) begin
      chosen = rr_core_i;
    end else if (lj <= la && lj <= lb) begin
      chosen = core_j;
    end else if (la <= lb) begin
      chosen = core_a;
    end else begin
      chosen = core_b;
    end

    pick_o.assigned = mode_i | hit;
    if (pick_o.assigned) begin
      pick_o.core = chosen;
      pick_o.cost = (aff_at(chosen, aff_i) == task_type_i) ? CostFast : CostSlow;
    end else begin
      pick_o.core = Core0;
      pick_o.cost = CostNone;
    end
  end

endmodule
`default_nettype wire

>>> sv/atca_state.sv
// Core loads, batch position and saturating run total
`default_nettype none
module atca_state #(
  parameter int unsigned BATCH_SIZE = atca_pkg::BatchSizeDef
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      step_i,
  input  atca_pkg::pick_t                           pick_i,
  output atca_pkg::load_t [atca_pkg::NumCores-1:0]  load_o,
  output logic [atca_pkg::CoreW-1:0]                rr_core_o,
  output atca_pkg::batch_t                          batch_o
);
  import atca_pkg::*;

  load_t [NumCores-1:0] load_q, load_d, load_new;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [CoreW-1:0]     rr_q, rr_d;
  logic [TotalW-1:0]    total_q, total_d;
  logic [CntW-1:0]      pos_inc;
  logic [LoadW:0]       sum_load;
  logic [TotalW:0]      sum_total;
  load_t                load_max;
  logic                 last;

  always_comb begin
    for (int k = 0; k < NumCores; k++) begin
      if (pick_i.assigned && pick_i.core == CoreW'(k)) begin
        sum_load    = {1'b0, load_q[k]} + (LoadW+1)'(pick_i.cost);
        load_new[k] = sum_load[LoadW] ? '1 : sum_load[LoadW-1:0];
      end else begin
        sum_load    = '0;
        load_new[k] = load_q[k];
      end
    end
    load_max = load_new[0];
    if (load_new[1] > load_max) begin
      load_max = load_new[1];
    end
    if (load_new[2] > load_max) begin
      load_max = load_new[2];
    end

    pos_inc   = {1'b0, pos_q} + CntW'(1);
    last      = (pos_inc >= CntW'(BATCH_SIZE));
    sum_total = {1'b0, total_q} + (TotalW+1)'(load_max);

    if (last) begin
      total_d = sum_total[TotalW] ? '1 : sum_total[TotalW-1:0];
      load_d  = '0;
      pos_d   = '0;
      rr_d    = Core0;
    end else begin
      total_d = total_q;
      load_d  = load_new;
      pos_d   = pos_inc[PosW-1:0];
      rr_d    = (rr_q == Core2) ? Core0 : rr_q + 2'd1;
    end

    batch_o.last  = last;
    batch_o.span  = last ? load_max : '0;
    batch_o.total = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q  <= '0;
      pos_q   <= '0;
      rr_q    <= Core0;
      total_q <= '0;
    end else if (step_i) begin
      load_q  <= load_d;
      pos_q   <= pos_d;
      rr_q    <= rr_d;
      total_q <= total_d;
    end
  end

  assign load_o    = load_q;
  assign rr_core_o = rr_q;

endmodule
`default_nettype wire

>>> sv/affinity_task_core_assigner.sv
// Affinity task core assigner: top level with input, config and result registers
//
// Usage: each word on the s_axis channel carries one task type code. The block
// places the task on one of three cores, greedily by affinity (mode 0, where
// unmatched types stay unassigned) or round robin by batch position (mode 1),
// and returns one word per task on m_axis. m_axis_tlast marks the last word of
// each batch of BATCH_SIZE tasks, which carries batch time and updated total.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 mode,
// 1..3 core affinities); write only while no task is in flight.
// Path: a task word is captured in the input register and its result in the
// result register.
// Throughput: one task per cycle while m_axis_tready is high; the choice, the
// load update and the total add sit between the input and result registers.
// Stall: while the receiver holds m_axis_tready low the result is held and the
// input register still takes one more word, then s_axis_tready drops.
// Reset: loads, batch position and total clear, mode returns to greedy and
// the affinities return to 'H', 'M' and 'L'.
`default_nettype none
`include "affinity_task_core_assigner_assert.svh"
module affinity_task_core_assigner #(
  parameter int unsigned BATCH_SIZE = atca_pkg::BatchSizeDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] task_type
  input  logic [atca_pkg::TypeW-1:0]      s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] assigned, [2:1] core_sel, [4:3] task_cost, [12:5] batch_time,
  // [44:13] total_time, [47:45] zero
  output logic [atca_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic [atca_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [atca_pkg::CfgDataW-1:0]   cfg_data_i
);
  import atca_pkg::*;

  logic                 in_vld_q, in_vld_d;
  type_t                in_type_q;
  logic                 out_vld_q, out_vld_d;
  pick_t                out_pick_q;
  batch_t               out_batch_q;
  logic                 mode_q;
  type_t [NumCores-1:0] aff_q;
  logic                 s_fire, advance;

  load_t [NumCores-1:0] load;
  logic [CoreW-1:0]     rr_core;
  pick_t                pick;
  batch_t               batch;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_fire) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_type_q <= s_axis_tdata;
    end
    if (advance) begin
      out_pick_q  <= pick;
      out_batch_q <= batch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      aff_q[0] <= AffReset0;
      aff_q[1] <= AffReset1;
      aff_q[2] <= AffReset2;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegMode: mode_q   <= cfg_data_i[0];
        RegAff0: aff_q[0] <= cfg_data_i;
        RegAff1: aff_q[1] <= cfg_data_i;
        RegAff2: aff_q[2] <= cfg_data_i;
        default: mode_q   <= mode_q;
      endcase
    end
  end

  atca_pick u_pick (
    .mode_i      (mode_q),
    .rr_core_i   (rr_core),
    .task_type_i (in_type_q),
    .aff_i       (aff_q),
    .load_i      (load),
    .pick_o      (pick)
  );

  atca_state #(
    .BATCH_SIZE (BATCH_SIZE)
  ) u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .pick_i    (pick),
    .load_o    (load),
    .rr_core_o (rr_core),
    .batch_o   (batch)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_batch_q.last;
  assign m_axis_tdata  = {3'b000, out_batch_q.total, out_batch_q.span,
                          out_pick_q.cost, out_pick_q.core, out_pick_q.assigned};

  `ATCA_ASSERT(a_unassigned_zero, clk_i, rst_ni, (m_axis_tvalid && !out_pick_q.assigned) |-> (out_pick_q.core == Core0 && out_pick_q.cost == CostNone))
  `ATCA_ASSERT(a_span_only_at_end, clk_i, rst_ni, (m_axis_tvalid && !out_batch_q.last) |-> (out_batch_q.span == '0))
  `ATCA_ASSERT(a_cost_iff_assigned, clk_i, rst_ni, m_axis_tvalid |-> (out_pick_q.assigned == (out_pick_q.cost != CostNone)))
  `ATCA_ASSERT(a_full_blocks_input, clk_i, rst_ni, (in_vld_q && out_vld_q && !m_axis_tready) |-> !s_axis_tready)
  `ATCA_ASSERT_NEXT(a_take_fills, clk_i, rst_ni, s_fire, in_vld_q)

endmodule
`default_nettype wire

>>> test/tb_affinity_task_core_assigner.sv
// Self-checking bench for the affinity task core assigner: random and directed task words
module tb_affinity_task_core_assigner;
  import atca_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam type_t TypeH = 8'h48;
  localparam type_t TypeM = 8'h4d;
  localparam type_t TypeL = 8'h4c;

  typedef struct packed {
    batch_t batch;
    pick_t  pick;
  } dispatch_t;

  class core_dispatch_model;
    logic            rr_mode;
    type_t           affinity[NumCores];
    load_t           load[NumCores];
    int unsigned     position;
    logic [TotalW-1:0] total;
    dispatch_t       pending_dispatches[$];
    int unsigned     errors;

    function new();
      rr_mode     = 1'b0;
      affinity[0] = AffReset0;
      affinity[1] = AffReset1;
      affinity[2] = AffReset2;
      foreach (load[i]) load[i] = '0;
      position = 0;
      total    = '0;
      errors   = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] value);
      case (idx)
        RegMode: rr_mode     = value[0];
        RegAff0: affinity[0] = value;
        RegAff1: affinity[1] = value;
        RegAff2: affinity[2] = value;
        default: ;
      endcase
    endfunction

    function void predict_dispatch(type_t code);
      dispatch_t   d;
      int unsigned j, a, b, sel, lj, la, lb, nl, peak;
      logic        placed;
      logic [TotalW:0] sum;
      d      = '0;
      placed = 1'b0;
      sel    = 0;
      if (rr_mode) begin
        placed = 1'b1;
        sel    = position % NumCores;
      end else begin
        j = NumCores;
        for (int i = NumCores - 1; i >= 0; i--) begin
          if (affinity[i] == code) j = i;
        end
        if (j < NumCores) begin
          placed = 1'b1;
          a  = (j + 1) % NumCores;
          b  = (j + 2) % NumCores;
          lj = load[j] + 1;
          la = load[a] + 2;
          lb = load[b] + 2;
          if (lj <= la && lj <= lb) sel = j;
          else if (la <= lb) sel = a;
          else sel = b;
        end
      end
      if (placed) begin
        d.pick.assigned = 1'b1;
        d.pick.core     = sel[CoreW-1:0];
        d.pick.cost     = (affinity[sel] == code) ? CostFast : CostSlow;
        nl = load[sel] + d.pick.cost;
        load[sel] = (nl > 255) ? 8'hff : nl[LoadW-1:0];
      end
      position = (position + 1) & 6'h3f;
      if (position >= BatchSizeDef || position == 0) begin
        peak = load[0];
        if (load[1] > peak) peak = load[1];
        if (load[2] > peak) peak = load[2];
        sum   = total + peak;
        total = sum[TotalW] ? '1 : sum[TotalW-1:0];
        d.batch.last = 1'b1;
        d.batch.span = peak[LoadW-1:0];
        foreach (load[i]) load[i] = '0;
        position = 0;
      end
      d.batch.total = total;
      pending_dispatches = {pending_dispatches, d};
    endfunction

    function void compare_field(string name, logic [TotalW-1:0] want, logic [TotalW-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_dispatch(logic [OutDataW-1:0] word, logic last);
      dispatch_t d;
      if (pending_dispatches.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, word);
        errors++;
        return;
      end
      d = pending_dispatches.pop_front();
      compare_field("assigned", d.pick.assigned, word[0]);
      compare_field("core_sel", d.pick.core, word[2:1]);
      compare_field("task_cost", d.pick.cost, word[4:3]);
      compare_field("batch_end", d.batch.last, last);
      compare_field("batch_time", d.batch.span, word[12:5]);
      compare_field("total_time", d.batch.total, word[44:13]);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  type_t                 s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we_i = 1'b0;
  cfg_reg_e              cfg_idx_i = RegMode;
  logic [CfgDataW-1:0]   cfg_data_i = '0;

  core_dispatch_model    model = new();
  int unsigned           tx_idle_pct = 0;
  int unsigned           rx_idle_pct = 0;
  int unsigned           quiet_cycles = 0;

  affinity_task_core_assigner DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) model.predict_dispatch(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) model.check_dispatch(m_axis_tdata, m_axis_tlast);
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("affinity_task_core_assigner test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_task(type_t code);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // drop valid and wait until every word has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (model.pending_dispatches.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    model.write_reg(idx, value);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic type_t pick_affinity(int unsigned core);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) begin
      case (core)
        0:       return TypeH;
        1:       return TypeM;
        default: return TypeL;
      endcase
    end
    if (r < 70 || core == 0) return type_t'($urandom_range(255));
    return model.affinity[$urandom_range(core - 1)];
  endfunction

  function automatic type_t pick_task_type();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return model.affinity[$urandom_range(NumCores - 1)];
    if (r < 85) begin
      case ($urandom_range(2))
        0:       return TypeH;
        1:       return TypeM;
        default: return TypeL;
      endcase
    end
    return type_t'($urandom_range(255));
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset affinities, greedy spill to other cores and unmatched types
    send_task(TypeH);
    send_task(TypeH);
    send_task(TypeH);
    send_task(TypeM);
    send_task(TypeL);
    send_task(8'h00);
    send_task(8'hff);
    send_task(8'h58);
    send_task(TypeM);
    drain();

    // repeated and extreme affinities, changed mid batch
    write_reg(RegAff0, 8'h00);
    write_reg(RegAff1, 8'hff);
    write_reg(RegAff2, 8'h00);
    send_task(8'h00);
    send_task(8'h00);
    send_task(8'h00);
    send_task(8'hff);
    send_task(8'hff);
    send_task(8'haa);
    drain();

    // round robin, upper value bits dropped
    write_reg(RegMode, 8'hff);
    send_task(TypeH);
    send_task(8'h00);
    send_task(8'h55);
    send_task(8'hff);
    send_task(TypeM);
    drain();
    write_reg(RegMode, 8'hfe);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 19;
          rx_idle_pct = 79;
        end
        1: begin
          tx_idle_pct = 79;
          rx_idle_pct = 19;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 5; seg++) begin
        drain();
        write_reg(RegAff0, pick_affinity(0));
        write_reg(RegAff1, pick_affinity(1));
        write_reg(RegAff2, pick_affinity(2));
        write_reg(RegMode, {7'($urandom_range(127)), 1'($urandom_range(3) == 0)});
        for (int n = 0; n < 110; n++) send_task(pick_task_type());
      end
    end
    drain();

    if (model.errors == 0 && model.pending_dispatches.size() == 0) begin
      $display("affinity_task_core_assigner test passed");
    end else begin
      $display("affinity_task_core_assigner test failed");
    end
    $finish;
  end

endmodule
